// File: sv/can_frame_to_slcan_ascii_defines.svh
// Assertion macros for the CAN frame to ASCII line encoder
`ifndef CAN_FRAME_TO_SLCAN_ASCII_DEFINES_SVH
`define CAN_FRAME_TO_SLCAN_ASCII_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet while in reset
`define CFSA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, quiet while in reset
`define CFSA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/cfsa_pkg.sv
// Shared types, character codes and helpers of the CAN frame ASCII encoder
`timescale 1ns / 1ps
package cfsa_pkg;

	localparam logic [7:0] CH_T_EXT = 8'h54; // 'T'
	localparam logic [7:0] CH_R_EXT = 8'h52; // 'R'
	localparam logic [7:0] CH_T_STD = 8'h74; // 't'
	localparam logic [7:0] CH_R_STD = 8'h72; // 'r'
	localparam logic [7:0] CH_A     = 8'h41; // 'A'
	localparam logic [7:0] CH_0     = 8'h30; // '0'
	localparam logic [7:0] CH_CR    = 8'h0D;

	localparam int unsigned WORD_W = 64;
	localparam logic [3:0]  MAX_DATA_BYTES = 4'd8;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TYPE,
		ST_ID,
		ST_DLC,
		ST_DATA,
		ST_TS,
		ST_CR
	} seq_state_t;

	typedef struct packed {
		seq_state_t cur;
		seq_state_t nxt;
		logic       load;
		logic       shift;
	} seq_ctl_t;

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		logic [7:0] c;
		if (n > 4'd9) begin
			c = CH_A + {4'd0, n} - 8'd10;
		end else begin
			c = CH_0 + {4'd0, n};
		end
		return c;
	endfunction

	// Data digits minus one, for a non-empty data field
	function automatic logic [3:0] data_digits_m1(input logic [3:0] nbytes);
		logic [4:0] d;
		d = {nbytes, 1'b0} - 5'd1;
		return d[3:0];
	endfunction

endpackage

// File: sv/cfsa_frame_if.sv
// Frame request channel of the CAN frame ASCII encoder
`timescale 1ns / 1ps
interface cfsa_frame_if;
	logic        valid;
	logic        ready;
	logic        is_extended;
	logic        is_remote;
	logic [28:0] frame_id;
	logic [3:0]  length_code;
	logic [63:0] payload;
	logic [15:0] time_stamp;

	modport source (
		output valid, is_extended, is_remote, frame_id, length_code, payload, time_stamp,
		input  ready
	);
	modport sink (
		input  valid, is_extended, is_remote, frame_id, length_code, payload, time_stamp,
		output ready
	);
endinterface

// File: sv/cfsa_char_if.sv
// Character request channel of the CAN frame ASCII encoder
`timescale 1ns / 1ps
interface cfsa_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] ascii_char;
	logic       last_char;

	modport source (output valid, ascii_char, last_char, input ready);
	modport sink (input valid, ascii_char, last_char, output ready);
endinterface

// File: sv/cfsa_cfg_if.sv
// Configuration write channel of the CAN frame ASCII encoder
`timescale 1ns / 1ps
interface cfsa_cfg_if;
	logic valid;
	logic ready;
	logic timestamp_enable;

	modport source (output valid, timestamp_enable, input ready);
	modport sink (input valid, timestamp_enable, output ready);
endinterface

// File: sv/can_frame_to_slcan_ascii.sv
// Top level of the CAN frame to serial-line ASCII encoder
`timescale 1ns / 1ps
`include "can_frame_to_slcan_ascii_defines.svh"
// Turns one received CAN frame into its serial-line ASCII receive line, one
// character per request on char_out: type letter (t, r, T or R), identifier in
// upper-case hex (three digits standard, eight extended), one DLC digit, two
// hex digits per data byte (none for remote frames, at most eight bytes even
// when the DLC reads above eight), four timestamp digits when timestamp
// enable is set, and a carriage return flagged with last_char. The frame is
// captured on acceptance and a single 64-bit nibble shifter, reloaded at each
// field boundary by a small sequencer, produces one hex digit per cycle while
// the sink keeps up. A frame occupies the block until its carriage return has
// entered the output register, so sink stalls stretch its stay.
// frame_in is ready only between lines; the final character may still wait
// in the output register while the next frame is accepted. Write the
// configuration only while idle; cfg is always ready.
module can_frame_to_slcan_ascii
	import cfsa_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	cfsa_frame_if.sink   frame_in,
	cfsa_char_if.source  char_out,
	cfsa_cfg_if.sink     cfg
);

	// captured frame
	logic        ext_q;
	logic        rtr_q;
	logic [28:0] id_q;
	logic [3:0]  dlc_q;
	logic [63:0] payload_q;
	logic [15:0] ts_q;

	logic        ts_en_q;

	// output register
	logic        ovld_q;
	logic [7:0]  ochar_q;
	logic        olast_q;

	seq_ctl_t    ctl;
	logic        start;
	logic        adv;
	logic [WORD_W-1:0] load_word;
	logic [7:0]  digit_char;
	logic [7:0]  char_nxt;

	// take a new frame only between lines
	assign frame_in.ready = (ctl.cur == ST_IDLE);
	assign start          = frame_in.valid && frame_in.ready;

	// advance one character whenever the output register is free or draining
	assign adv = (ctl.cur != ST_IDLE) && (!ovld_q || char_out.ready);

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ts_en_q <= 1'b0;
		end else if (cfg.valid) begin
			ts_en_q <= cfg.timestamp_enable;
		end
	end

	// hold the frame fields for the whole line
	always_ff @(posedge clk) begin
		if (start) begin
			ext_q     <= frame_in.is_extended;
			rtr_q     <= frame_in.is_remote;
			id_q      <= frame_in.frame_id;
			dlc_q     <= frame_in.length_code;
			payload_q <= frame_in.payload;
			ts_q      <= frame_in.time_stamp;
		end
	end

	cfsa_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.adv    (adv),
		.is_ext (ext_q),
		.is_rtr (rtr_q),
		.dlc    (dlc_q),
		.ts_en  (ts_en_q),
		.ctl    (ctl)
	);

	// left-align the next field in the shifter so its first digit sits on top
	always_comb begin
		case (ctl.nxt)
			ST_ID:   load_word = ext_q ? {3'd0, id_q, 32'd0} : {id_q[11:0], 52'd0};
			ST_DLC:  load_word = {dlc_q, 60'd0};
			ST_DATA: load_word = payload_q;
			ST_TS:   load_word = {ts_q, 48'd0};
			default: load_word = '0;
		endcase
	end

	cfsa_nib_shift u_shift (
		.clk        (clk),
		.load       (ctl.load),
		.shift      (ctl.shift),
		.load_word  (load_word),
		.digit_char (digit_char)
	);

	// pick the character for the current field
	always_comb begin
		case (ctl.cur)
			ST_TYPE: begin
				if (ext_q) char_nxt = rtr_q ? CH_R_EXT : CH_T_EXT;
				else char_nxt = rtr_q ? CH_R_STD : CH_T_STD;
			end
			ST_CR:   char_nxt = CH_CR;
			default: char_nxt = digit_char;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q <= 1'b0;
		end else if (adv) begin
			ovld_q <= 1'b1;
		end else if (char_out.ready) begin
			ovld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ochar_q <= char_nxt;
			olast_q <= (ctl.cur == ST_CR);
		end
	end

	assign char_out.valid      = ovld_q;
	assign char_out.ascii_char = ochar_q;
	assign char_out.last_char  = olast_q;

	// an accepted frame always opens with its type letter
	`CFSA_ASSERT_NEXT(a_start_type, start, ctl.cur == ST_TYPE, "frame accepted but no type letter next")
	// the line end flag travels only with a carriage return
	`CFSA_ASSERT_NOW(a_last_cr, ovld_q && olast_q, ochar_q == CH_CR, "last_char without carriage return")
	// no new request while a line is in progress
	`CFSA_ASSERT_NOW(a_busy, ctl.cur != ST_IDLE, !frame_in.ready, "frame ready during a line")

endmodule

// File: sv/cfsa_nib_shift.sv
// Shared nibble shifter with hex digit encoder
`timescale 1ns / 1ps
module cfsa_nib_shift
	import cfsa_pkg::*;
(
	input  logic              clk,
	input  logic              load,
	input  logic              shift,
	input  logic [WORD_W-1:0] load_word,
	output logic [7:0]        digit_char
);

	logic [WORD_W-1:0] sh_q;

	always_ff @(posedge clk) begin
		if (load) begin
			sh_q <= load_word;
		end else if (shift) begin
			sh_q <= {sh_q[WORD_W-5:0], 4'd0};
		end
	end

	assign digit_char = hex_char(sh_q[WORD_W-1 -: 4]);

endmodule

// File: sv/cfsa_seq.sv
// Field sequencer and digit counter of the CAN frame ASCII encoder
`timescale 1ns / 1ps
module cfsa_seq
	import cfsa_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic       adv,
	input  logic       is_ext,
	input  logic       is_rtr,
	input  logic [3:0] dlc,
	input  logic       ts_en,
	output seq_ctl_t   ctl
);

	seq_state_t state_q;
	seq_state_t state_nxt;
	logic [3:0] cnt_q;
	logic [3:0] cnt_init;
	logic [3:0] nbytes;
	logic       change;

	assign nbytes = is_rtr ? 4'd0 : (dlc > MAX_DATA_BYTES ? MAX_DATA_BYTES : dlc);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: if (start) state_nxt = ST_TYPE;
			ST_TYPE: if (adv) state_nxt = ST_ID;
			ST_ID: if (adv && cnt_q == 4'd0) state_nxt = ST_DLC;
			ST_DLC: begin
				if (adv) begin
					if (nbytes != 4'd0) state_nxt = ST_DATA;
					else if (ts_en) state_nxt = ST_TS;
					else state_nxt = ST_CR;
				end
			end
			ST_DATA: if (adv && cnt_q == 4'd0) state_nxt = ts_en ? ST_TS : ST_CR;
			ST_TS: if (adv && cnt_q == 4'd0) state_nxt = ST_CR;
			ST_CR: if (adv) state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		change = (state_nxt != state_q);
		ctl.cur   = state_q;
		ctl.nxt   = state_nxt;
		ctl.load  = change;
		ctl.shift = adv && !change;
		case (state_nxt)
			ST_ID:   cnt_init = is_ext ? 4'd7 : 4'd2;
			ST_DATA: cnt_init = data_digits_m1(nbytes);
			ST_TS:   cnt_init = 4'd3;
			default: cnt_init = 4'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= 4'd0;
		end else begin
			state_q <= state_nxt;
			if (change) begin
				cnt_q <= cnt_init;
			end else if (adv) begin
				cnt_q <= cnt_q - 4'd1;
			end
		end
	end

endmodule

// File: verif/testbench.sv
// Self-checking testbench for the CAN frame to serial-line ASCII encoder
`timescale 1ns / 1ps
// Drives CAN frames into the encoder and checks every character of each ASCII
// line it sends back. A short directed table comes first. It covers the
// identifier extremes, standard and extended, data and remote frames, DLC 0,
// DLC above eight and the timestamp digits. Rows whose line is obvious carry
// the expected text typed in; the rest go through the line predictor below.
// About 420 random frames follow in phases that alternate the timestamp
// setting. Both the frame sender and the character sink pause at random.
module testbench;
	import cfsa_pkg::*;

	localparam int unsigned HALF_PERIOD      = 5;
	localparam int unsigned RESET_CYCLES     = 4;
	localparam int unsigned SETTLE_CYCLES    = 8;
	localparam int unsigned STALL_LIMIT      = 1000;
	localparam int unsigned RANDOM_PHASES    = 6;
	localparam int unsigned FRAMES_PER_PHASE = 70;
	localparam int unsigned CALM_STRETCH     = 20;
	localparam int unsigned DIRECTED_ROWS    = 18;

	typedef struct packed {
		logic        ext;
		logic        rtr;
		logic [28:0] id;
		logic [3:0]  dlc;
		logic [63:0] data;
		logic [15:0] stamp;
	} can_frame_t;

	typedef struct packed {
		logic [7:0] ascii;
		logic       is_last;
	} line_char_t;

	// text holds the line without its carriage return; empty means "predict it"
	typedef struct {
		bit         stamp_en;
		can_frame_t frame;
		string      text;
	} directed_row_t;

	directed_row_t directed_rows [DIRECTED_ROWS] = '{
		'{1'b0, '{1'b0, 1'b0, 29'h0000000, 4'h0, 64'h0, 16'h0000}, "t0000"},
		'{1'b0, '{1'b0, 1'b0, 29'h00007FF, 4'h8, 64'h0123456789ABCDEF, 16'h0000},
			"t7FF80123456789ABCDEF"},
		'{1'b0, '{1'b0, 1'b1, 29'h0000123, 4'h4, '1, 16'h0000}, "r1234"},
		'{1'b0, '{1'b1, 1'b0, 29'h1FFFFFFF, 4'hF, '1, 16'hFFFF},
			"T1FFFFFFFFFFFFFFFFFFFFFFFF"},
		'{1'b0, '{1'b1, 1'b1, 29'h0000000, 4'h0, 64'h0, 16'h0000}, "R000000000"},
		'{1'b0, '{1'b0, 1'b0, 29'h1FFFFABC, 4'h9, 64'hFEDCBA9876543210, 16'h0000},
			"tABC9FEDCBA9876543210"},
		'{1'b0, '{1'b0, 1'b0, 29'h0000001, 4'h1, 64'hA500000000000000, 16'h0000},
			"t0011A5"},
		'{1'b0, '{1'b1, 1'b0, 29'h0ABCDEF1, 4'h8, 64'h5A5A5A5AC3C3C3C3, 16'h1357}, ""},
		'{1'b0, '{1'b0, 1'b1, 29'h0000000, 4'hF, 64'h0, 16'h0000}, "r000F"},
		'{1'b0, '{1'b1, 1'b0, 29'h12345678, 4'h3, 64'hDEADBEEF00000000, 16'h2468}, ""},
		'{1'b1, '{1'b0, 1'b0, 29'h0000000, 4'h0, 64'h0, 16'h0000}, "t00000000"},
		'{1'b1, '{1'b1, 1'b1, 29'h1FFFFFFF, 4'h8, '1, 16'hFFFF}, "R1FFFFFFF8FFFF"},
		'{1'b1, '{1'b0, 1'b0, 29'h00007FF, 4'h8, '1, 16'h1234}, ""},
		'{1'b1, '{1'b1, 1'b0, 29'h1FFFFFFF, 4'hF, '1, 16'hFFFF}, ""},
		'{1'b1, '{1'b0, 1'b0, 29'h00002A5, 4'h2, 64'h0F0F0F0F0F0F0F0F, 16'hA5C3}, ""},
		'{1'b1, '{1'b1, 1'b0, 29'h0000001, 4'hC, 64'h0011223344556677, 16'h8001}, ""},
		'{1'b0, '{1'b0, 1'b0, 29'h0000800, 4'h1, 64'h8000000000000000, 16'hFFFF},
			"t800180"},
		'{1'b0, '{1'b1, 1'b0, 29'h15555555, 4'h7, 64'h1122334455667788, 16'h0000}, ""}
	};

	logic clk = 1'b0;
	logic arst_n;

	cfsa_frame_if frame_ch();
	cfsa_char_if  char_ch();
	cfsa_cfg_if   cfg_ch();

	can_frame_to_slcan_ascii dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.frame_in (frame_ch),
		.char_out (char_ch),
		.cfg      (cfg_ch)
	);

	always #HALF_PERIOD clk = ~clk;

	// Characters still owed by the encoder, oldest first
	line_char_t  line_chars_q[$];
	// Typed-in line per sent frame, empty where the predictor supplies it
	string       typed_lines_q[$];

	bit          stamp_shown;      // our copy of timestamp_enable
	bit          src_calm;
	int unsigned fault_count;
	int unsigned idle_cycles;
	int unsigned frames_seen, ext_seen, remote_seen, long_dlc_seen, stamped_seen;
	int unsigned chars_seen, cfg_writes;

	function automatic logic [7:0] nibble_ascii(input logic [3:0] n);
		if (n < 4'd10)
			return CH_0 + 8'(n);
		return CH_A + 8'(n - 4'd10);
	endfunction

	// Build the whole ASCII line of one frame and queue it character by character
	function automatic void encode_frame_line(input can_frame_t f, input bit stamp_on);
		logic [31:0] id32;
		logic [7:0]  letter;
		int          id_digits;
		int          data_digits;
		id32 = {3'b000, f.id};
		if (f.ext) begin
			letter = f.rtr ? CH_R_EXT : CH_T_EXT;
		end else begin
			letter = f.rtr ? CH_R_STD : CH_T_STD;
		end
		line_chars_q.push_back('{letter, 1'b0});
		// standard frames show only the low three nibbles, whatever sits above
		id_digits = f.ext ? 8 : 3;
		for (int i = id_digits - 1; i >= 0; i--)
			line_chars_q.push_back('{nibble_ascii(id32[4*i +: 4]), 1'b0});
		// the DLC digit is always the raw code, even when it reads above eight
		line_chars_q.push_back('{nibble_ascii(f.dlc), 1'b0});
		data_digits = f.rtr ? 0 : 2 * ((f.dlc > MAX_DATA_BYTES) ? MAX_DATA_BYTES : f.dlc);
		for (int i = 0; i < data_digits; i++)
			line_chars_q.push_back('{nibble_ascii(f.data[63 - 4*i -: 4]), 1'b0});
		if (stamp_on) begin
			for (int i = 3; i >= 0; i--)
				line_chars_q.push_back('{nibble_ascii(f.stamp[4*i +: 4]), 1'b0});
		end
		line_chars_q.push_back('{CH_CR, 1'b1});
	endfunction

	// Mostly short pauses, now and then a long one
	function automatic int unsigned gap_length();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 7)
			return $urandom_range(1, 3);
		if (r < 9)
			return $urandom_range(4, 8);
		return $urandom_range(12, 40);
	endfunction

	function automatic can_frame_t random_frame();
		can_frame_t  f;
		logic [31:0] w;
		w = $urandom();
		f.ext = 1'($urandom_range(0, 1));
		f.rtr = ($urandom_range(0, 4) == 0);
		// standard identifiers mostly in range, sometimes with junk above bit 10
		if (!f.ext && $urandom_range(0, 3) != 0)
			f.id = {18'd0, w[10:0]};
		else
			f.id = w[28:0];
		if ($urandom_range(0, 9) < 8)
			f.dlc = 4'($urandom_range(0, 8));
		else
			f.dlc = 4'($urandom_range(9, 15));
		f.data = {$urandom(), $urandom()};
		f.stamp = 16'($urandom_range(0, 65535));
		return f;
	endfunction

	// Offer one frame request; valid stays high afterwards so that a frame
	// sent with no gap follows without valid dropping in between
	task automatic send_frame(input can_frame_t f, input string text);
		int unsigned gap;
		gap = (src_calm || $urandom_range(0, 1) == 1) ? 0 : gap_length();
		if (gap != 0) begin
			frame_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		typed_lines_q.push_back(text);
		frame_ch.valid       <= 1'b1;
		frame_ch.is_extended <= f.ext;
		frame_ch.is_remote   <= f.rtr;
		frame_ch.frame_id    <= f.id;
		frame_ch.length_code <= f.dlc;
		frame_ch.payload     <= f.data;
		frame_ch.time_stamp  <= f.stamp;
		do @(posedge clk); while (!frame_ch.ready);
	endtask

	// Drop valid and hold until every owed character has come back, then let
	// the last carriage return clear the output register
	task automatic settle_idle();
		frame_ch.valid <= 1'b0;
		@(posedge clk);
		while (line_chars_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_stamp_enable(input bit value);
		cfg_ch.valid            <= 1'b1;
		cfg_ch.timestamp_enable <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	// Character sink: random stalls, with calm stretches of steady readiness
	int unsigned sink_hold;
	int unsigned sink_cycle;
	bit          sink_calm;

	always @(posedge clk) begin
		sink_cycle++;
		if (sink_cycle % 128 == 0)
			sink_calm = ($urandom_range(0, 3) == 0);
		if (sink_hold != 0) begin
			char_ch.ready <= 1'b0;
			sink_hold--;
		end else begin
			char_ch.ready <= 1'b1;
			if (!sink_calm && $urandom_range(0, 3) == 0)
				sink_hold = gap_length();
		end
	end

	// Monitor: track the register, predict on each frame request, check each
	// character request against the oldest owed character
	always @(posedge clk) begin
		line_char_t want;
		can_frame_t got;
		string      typed;
		bit         moved;
		if (arst_n) begin
			moved = 1'b0;
			if (cfg_ch.valid && cfg_ch.ready) begin
				stamp_shown = cfg_ch.timestamp_enable;
				cfg_writes++;
				moved = 1'b1;
			end
			if (char_ch.valid && char_ch.ready) begin
				chars_seen++;
				moved = 1'b1;
				if (line_chars_q.size() == 0) begin
					$error("ascii_char 0x%02h (last_char %0b) arrived with nothing owed",
						char_ch.ascii_char, char_ch.last_char);
					fault_count++;
				end else begin
					want = line_chars_q.pop_front();
					if (char_ch.ascii_char !== want.ascii) begin
						$error("ascii_char mismatch: expected 0x%02h, got 0x%02h",
							want.ascii, char_ch.ascii_char);
						fault_count++;
					end
					if (char_ch.last_char !== want.is_last) begin
						$error("last_char mismatch: expected %0b, got %0b",
							want.is_last, char_ch.last_char);
						fault_count++;
					end
				end
			end
			if (frame_ch.valid && frame_ch.ready) begin
				got.ext   = frame_ch.is_extended;
				got.rtr   = frame_ch.is_remote;
				got.id    = frame_ch.frame_id;
				got.dlc   = frame_ch.length_code;
				got.data  = frame_ch.payload;
				got.stamp = frame_ch.time_stamp;
				typed = (typed_lines_q.size() != 0) ? typed_lines_q.pop_front() : "";
				if (typed.len() == 0) begin
					encode_frame_line(got, stamp_shown);
				end else begin
					for (int k = 0; k < typed.len(); k++)
						line_chars_q.push_back('{typed[k], 1'b0});
					line_chars_q.push_back('{CH_CR, 1'b1});
				end
				frames_seen++;
				if (got.ext)
					ext_seen++;
				if (got.rtr)
					remote_seen++;
				if (got.dlc > MAX_DATA_BYTES)
					long_dlc_seen++;
				if (stamp_shown)
					stamped_seen++;
				moved = 1'b1;
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
		end
	end

	// Watchdog: give up when no request of any kind has moved for too long
	initial begin
		while (idle_cycles < STALL_LIMIT) @(posedge clk);
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		bit driven_stamp;
		arst_n                  = 1'b0;
		frame_ch.valid          = 1'b0;
		frame_ch.is_extended    = 1'b0;
		frame_ch.is_remote      = 1'b0;
		frame_ch.frame_id       = '0;
		frame_ch.length_code    = '0;
		frame_ch.payload        = '0;
		frame_ch.time_stamp     = '0;
		char_ch.ready           = 1'b0;
		cfg_ch.valid            = 1'b0;
		cfg_ch.timestamp_enable = 1'b0;
		src_calm                = 1'b0;
		driven_stamp            = 1'b0;   // timestamps are off out of reset
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: change the register only between rows that need it
		foreach (directed_rows[r]) begin
			if (directed_rows[r].stamp_en != driven_stamp) begin
				settle_idle();
				write_stamp_enable(directed_rows[r].stamp_en);
				driven_stamp = directed_rows[r].stamp_en;
			end
			send_frame(directed_rows[r].frame, directed_rows[r].text);
		end

		// Random frames, alternating the timestamp setting from phase to phase
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			settle_idle();
			write_stamp_enable(phase % 2 == 0);
			for (int k = 0; k < FRAMES_PER_PHASE; k++) begin
				if (k % CALM_STRETCH == 0)
					src_calm = ($urandom_range(0, 3) == 0);
				send_frame(random_frame(), "");
			end
		end

		settle_idle();
		if (line_chars_q.size() != 0) begin
			$error("%0d owed characters never arrived", line_chars_q.size());
			fault_count++;
		end
		$display("Covered %0d frames (%0d extended, %0d remote, %0d with DLC above eight)",
			frames_seen, ext_seen, remote_seen, long_dlc_seen);
		$display("%0d frames carried timestamps; %0d characters checked; %0d register writes",
			stamped_seen, chars_seen, cfg_writes);
		if (fault_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
